[hw/rtl/rpa_pkg.sv]
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types, codes and defaults of the reference-counted page allocator.
// ----------------------------------------------------------------------------
package rpa_pkg;

  // Field widths of the request and response
  localparam int unsigned PAGE_W     = 12;
  localparam int unsigned FUNC_W     = 3;
  localparam int unsigned VAL_W      = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CNT_OUT_W  = 8;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // Default parameter values
  localparam int unsigned DEF_NUM_PAGES  = 4096;
  localparam int unsigned DEF_COUNT_BITS = 8;

  // Request function codes
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_INC   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_GET   = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_SET   = 3'd5;

  // Response status codes
  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOFREE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_REFD   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_CAP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_START  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_START = 3'd5;

  // Configuration reset values
  localparam logic [PAGE_W-1:0] RST_FIRST_PAGE  = 12'd0;
  localparam logic [PCT_W-1:0]  RST_ALPHA       = 7'd25;
  localparam logic [PCT_W-1:0]  RST_BETA        = 7'd10;
  localparam logic [SIZE_W-1:0] RST_BATCH_CAP   = 13'd100;
  localparam logic [SIZE_W-1:0] RST_THR_START   = 13'd100;
  localparam logic [SIZE_W-1:0] RST_BATCH_START = 13'd4;

  // Percent scaling: floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x < 2**20
  localparam int unsigned PROD_W      = SIZE_W + PCT_W;
  localparam int unsigned RECIP_W     = 21;
  localparam int unsigned RECIP_SHIFT = 27;
  localparam logic [RECIP_W-1:0] RECIP_100 = 21'd1342178;
  localparam int unsigned QUOT_W      = 14;
  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [PAGE_W-1:0]       page;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]         status;
    logic [PAGE_W-1:0]           page_out;
    logic signed [CNT_OUT_W-1:0] ref_count;
    logic [SIZE_W-1:0]           swap_pages;
    logic [SIZE_W-1:0]           free_pages;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
  } dp_sts_t;

endpackage

[hw/rtl/refcounted_page_allocator_core.sv]
// ----------------------------------------------------------------------------
// refcounted_page_allocator_core
// Page allocator with a LIFO free stack, per-page reference counts and an
// adaptive swap threshold.
// ----------------------------------------------------------------------------
// After reset the block sweeps the reference table to zero, one page per
// cycle, with busy high until the sweep is done; configuration writes are
// taken during that time. A request is accepted when start is high and busy
// low; the reference table and free stack memories are read on acceptance,
// the execute state registers the result, and the response appears on
// rsp_o with done_o high for exactly one cycle.
// The receiver cannot stall: capture the response whenever done_o is high.
// A new request may be started in the same cycle that done_o is high.
// ----------------------------------------------------------------------------
module refcounted_page_allocator_core #(
  parameter int unsigned NUM_PAGES  = rpa_pkg::DEF_NUM_PAGES,
  parameter int unsigned COUNT_BITS = rpa_pkg::DEF_COUNT_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  rpa_pkg::req_t                  req_i,
  output logic                           done_o,
  output rpa_pkg::rsp_t                  rsp_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rpa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rpa_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import rpa_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // Config writes are always taken
  assign cfg_ready_o = 1'b1;

  rpa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  rpa_dp #(
    .NUM_PAGES  (NUM_PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

[hw/rtl/rpa_ram.sv]
// ----------------------------------------------------------------------------
// rpa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/rpa_dp.sv]
// ----------------------------------------------------------------------------
// rpa_dp
// Datapath: config registers, free stack and ref table memories, swap
// threshold/batch arithmetic and the response register.
// ----------------------------------------------------------------------------
module rpa_dp #(
  parameter int unsigned NUM_PAGES  = rpa_pkg::DEF_NUM_PAGES,
  parameter int unsigned COUNT_BITS = rpa_pkg::DEF_COUNT_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rpa_pkg::ctl_cmd_t                  cmd_i,
  output rpa_pkg::dp_sts_t                   sts_o,
  input  rpa_pkg::req_t                      req_i,
  output rpa_pkg::rsp_t                      rsp_o,
  input  logic                               cfg_valid_i,
  input  logic [rpa_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rpa_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  import rpa_pkg::*;

  localparam int unsigned AW = $clog2(NUM_PAGES);
  localparam int unsigned FW = $clog2(NUM_PAGES + 1);
  // Wide signed width for count arithmetic before saturation
  localparam int unsigned WW = ((COUNT_BITS > VAL_W) ? COUNT_BITS : VAL_W) + 2;
  localparam logic signed [WW-1:0] CNT_MAX =
    {{(WW - COUNT_BITS + 1){1'b0}}, {(COUNT_BITS - 1){1'b1}}};
  localparam logic signed [WW-1:0] CNT_MIN = ~CNT_MAX;
  localparam int unsigned BATCH_W = QUOT_W + 1;

  function automatic logic signed [COUNT_BITS-1:0] sat_cnt(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] r;
    r = v;
    if (v > CNT_MAX) begin
      r = CNT_MAX;
    end else if (v < CNT_MIN) begin
      r = CNT_MIN;
    end
    return r[COUNT_BITS-1:0];
  endfunction

  // Config registers
  logic [PAGE_W-1:0] first_page_q;
  logic [PCT_W-1:0]  alpha_q, beta_q;
  logic [SIZE_W-1:0] batch_cap_q;

  // Allocator state
  logic [SIZE_W-1:0] thr_q, thr_d;
  logic [SIZE_W-1:0] batch_q, batch_d;
  logic [FW-1:0]     free_total_q, free_total_d;
  logic [AW-1:0]     clr_cnt_q;

  // Captured request and registered percent products
  req_t              req_q;
  logic [PROD_W-1:0] prod_beta_q, prod_alpha_q;
  rsp_t              rsp_q, rsp_d;

  // Memory ports
  logic                         ref_mem_we;
  logic [AW-1:0]                ref_mem_waddr;
  logic [COUNT_BITS-1:0]        ref_mem_wdata;
  logic [COUNT_BITS-1:0]        ref_rdata;
  logic [PAGE_W-1:0]            stk_rdata;
  logic [FW-1:0]                ft_m1;

  // Execute-cycle decode
  logic                         ref_we, push, push_ok, pop, upd_swap;
  logic [AW-1:0]                ref_waddr;
  logic signed [COUNT_BITS-1:0] ref_wdata, cnt_out, old_cnt, dec_cnt, inc_cnt, set_cnt;
  logic signed [VAL_W-1:0]      val_s;
  logic                         in_table, freeable, trig;
  logic [RECIP_W+PROD_W-1:0]    scl_beta, scl_alpha;
  logic [QUOT_W-1:0]            shrink, growth;
  logic [SIZE_W-1:0]            thr_new, batch_new;
  logic [BATCH_W-1:0]           nb_sum, nb_cap;

  // Config writes and swap threshold/batch updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_page_q  <= RST_FIRST_PAGE;
      alpha_q       <= RST_ALPHA;
      beta_q        <= RST_BETA;
      batch_cap_q   <= RST_BATCH_CAP;
      thr_q         <= RST_THR_START;
      batch_q       <= RST_BATCH_START;
      free_total_q  <= '0;
      clr_cnt_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_FIRST_PAGE:  first_page_q  <= cfg_data_i[PAGE_W-1:0];
          CFG_ALPHA:       alpha_q       <= cfg_data_i[PCT_W-1:0];
          CFG_BETA:        beta_q        <= cfg_data_i[PCT_W-1:0];
          CFG_BATCH_CAP:   batch_cap_q   <= cfg_data_i;
          // start values load the running threshold and batch via thr_d/batch_d
          default: ;
        endcase
      end
      thr_q        <= thr_d;
      batch_q      <= batch_d;
      free_total_q <= free_total_d;
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
    end
  end

  // Request capture, percent products and response register
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q        <= req_i;
      prod_beta_q  <= PROD_W'(thr_q) * PROD_W'(beta_q);
      prod_alpha_q <= PROD_W'(batch_q) * PROD_W'(alpha_q);
    end
    if (cmd_i.exec) begin
      rsp_q <= rsp_d;
    end
  end

  assign sts_o.clear_last = cmd_i.clear && (clr_cnt_q == AW'(NUM_PAGES - 1));

  // Ref table: clearing pass after reset, else read on accept / write on execute
  assign ref_mem_we    = cmd_i.clear || (cmd_i.exec && ref_we);
  assign ref_mem_waddr = cmd_i.clear ? clr_cnt_q : ref_waddr;
  assign ref_mem_wdata = cmd_i.clear ? '0 : ref_wdata;

  rpa_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_PAGES)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ref_mem_we),
    .waddr_i (ref_mem_waddr),
    .wdata_i (ref_mem_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (AW'(req_i.page)),
    .rdata_o (ref_rdata)
  );

  // Free stack: top entry read on accept, push on execute
  assign ft_m1 = free_total_q - FW'(1);

  rpa_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (NUM_PAGES)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec && push_ok),
    .waddr_i (AW'(free_total_q)),
    .wdata_i (req_q.page),
    .re_i    (cmd_i.accept),
    .raddr_i (AW'(ft_m1)),
    .rdata_o (stk_rdata)
  );

  // Count arithmetic with saturation
  assign val_s   = req_q.value;
  assign old_cnt = ref_rdata;
  assign dec_cnt = sat_cnt(((req_q.func == FUNC_ADD) ? '0 : WW'(old_cnt)) - WW'(1));
  assign inc_cnt = sat_cnt(WW'(old_cnt) + WW'(1));
  assign set_cnt = sat_cnt(WW'(val_s));

  assign in_table = 32'(req_q.page) < 32'(NUM_PAGES);
  assign freeable = in_table && (req_q.page >= first_page_q);
  assign trig     = 32'(free_total_q) <= 32'(thr_q);

  // Threshold shrink and batch growth, divide by 100 through reciprocal
  assign scl_beta  = (RECIP_W + PROD_W)'(prod_beta_q) * (RECIP_W + PROD_W)'(RECIP_100);
  assign scl_alpha = (RECIP_W + PROD_W)'(prod_alpha_q) * (RECIP_W + PROD_W)'(RECIP_100);
  assign shrink    = scl_beta[RECIP_SHIFT +: QUOT_W];
  assign growth    = scl_alpha[RECIP_SHIFT +: QUOT_W];
  assign thr_new   = (shrink >= QUOT_W'(thr_q)) ? '0 : (thr_q - SIZE_W'(shrink));
  assign nb_sum    = BATCH_W'(batch_q) + BATCH_W'(growth);

  always_comb begin
    nb_cap = nb_sum;
    if (nb_cap > BATCH_W'(batch_cap_q)) begin
      nb_cap = BATCH_W'(batch_cap_q);
    end
    if (nb_cap > BATCH_W'(SIZE_MAX)) begin
      nb_cap = BATCH_W'(SIZE_MAX);
    end
    batch_new = SIZE_W'(nb_cap);
  end

  // Execute decode
  always_comb begin
    rsp_d      = '0;
    ref_we     = 1'b0;
    ref_waddr  = AW'(req_q.page);
    ref_wdata  = '0;
    cnt_out    = '0;
    push       = 1'b0;
    pop        = 1'b0;
    upd_swap   = 1'b0;
    rsp_d.status = STATUS_OK;
    unique case (req_q.func)
      FUNC_ADD, FUNC_FREE: begin
        if (!freeable) begin
          rsp_d.status = STATUS_BAD;
        end else begin
          ref_we    = 1'b1;
          ref_wdata = dec_cnt;
          cnt_out   = dec_cnt;
          if (!dec_cnt[COUNT_BITS-1] && (dec_cnt != '0)) begin
            rsp_d.status = STATUS_REFD;
          end else begin
            push = 1'b1;
          end
        end
      end
      FUNC_ALLOC: begin
        if (trig) begin
          upd_swap         = 1'b1;
          rsp_d.swap_pages = batch_q;
        end
        if (free_total_q == '0) begin
          rsp_d.status = STATUS_NOFREE;
        end else begin
          pop            = 1'b1;
          ref_we         = 1'b1;
          ref_waddr      = AW'(stk_rdata);
          ref_wdata      = COUNT_BITS'(1);
          cnt_out        = COUNT_BITS'(1);
          rsp_d.page_out = stk_rdata;
        end
      end
      FUNC_INC, FUNC_GET, FUNC_SET: begin
        if (!in_table) begin
          rsp_d.status = STATUS_BAD;
        end else if (req_q.func == FUNC_INC) begin
          ref_we    = 1'b1;
          ref_wdata = inc_cnt;
          cnt_out   = inc_cnt;
        end else if (req_q.func == FUNC_SET) begin
          ref_we    = 1'b1;
          ref_wdata = set_cnt;
          cnt_out   = set_cnt;
        end else begin
          cnt_out = old_cnt;
        end
      end
      default: ;
    endcase
    rsp_d.ref_count  = CNT_OUT_W'(cnt_out);
    rsp_d.free_pages = SIZE_W'(free_total_d);
  end

  assign push_ok = push && (free_total_q != FW'(NUM_PAGES));

  // Next state of the counters
  always_comb begin
    free_total_d = free_total_q;
    thr_d        = thr_q;
    batch_d      = batch_q;
    if (cmd_i.exec) begin
      if (push_ok) begin
        free_total_d = free_total_q + FW'(1);
      end else if (pop) begin
        free_total_d = ft_m1;
      end
      if (upd_swap) begin
        thr_d   = thr_new;
        batch_d = batch_new;
      end
    end
    if (cfg_valid_i && (cfg_index_i == CFG_THR_START)) begin
      thr_d = cfg_data_i;
    end
    if (cfg_valid_i && (cfg_index_i == CFG_BATCH_START)) begin
      batch_d = cfg_data_i;
    end
  end

  assign rsp_o = rsp_q;

  // A rejected page never touches the table or the stack
  a_bad_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && (rsp_d.status == STATUS_BAD) |-> !ref_we && !push_ok)
    else $error("rejected page modified state");

  // A successful pop takes exactly one page off the stack
  a_pop_dec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && (req_q.func == FUNC_ALLOC) && (free_total_q != '0)
    |=> free_total_q == $past(free_total_q) - FW'(1))
    else $error("alloc did not pop one page");

endmodule

[hw/rtl/rpa_ctrl.sv]
// ----------------------------------------------------------------------------
// rpa_ctrl
// Controller: clearing pass after reset, then accept / execute sequencing.
// ----------------------------------------------------------------------------
module rpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  output rpa_pkg::ctl_cmd_t cmd_o,
  input  rpa_pkg::dp_sts_t  sts_i
);

  import rpa_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (sts_i.clear_last) state_d = S_IDLE;
      S_IDLE:  if (start) state_d = S_EXEC;
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  // State and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_EXEC);
    end
  end

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign cmd_o.clear  = (state_q == S_CLEAR);
  assign cmd_o.accept = start && (state_q == S_IDLE);
  assign cmd_o.exec   = (state_q == S_EXEC);

  // Every accepted request answers with a done strobe after the execute state
  a_accept_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |-> ##2 done_q)
    else $error("accepted request produced no response");

  // The strobe only appears while idle again
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("response strobe outside idle");

  // The clearing pass runs once after reset
  a_clear_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_CLEAR) |=> (state_q != S_CLEAR))
    else $error("clearing pass re-entered");

endmodule
